// ===== src/rss_pkg.sv =====
package rss_pkg;

  // data widths fixed by the interface
  localparam int DIST_W  = 12;
  localparam int ANGLE_W = 11;
  localparam int SLOT_W  = 4;
  localparam int WIDTH_W = 23;
  localparam int SKIP_W  = 7;
  localparam int STEP_W  = 4;
  localparam int CFG_W   = 12;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  // register reset values
  localparam logic [DIST_W-1:0] NEAR_THRESHOLD_RST = 12'd100;
  localparam logic [SKIP_W-1:0] SKIP_COUNT_RST     = 7'd3;
  localparam logic [SKIP_W-1:0] MIN_SPAN_RST       = 7'd2;
  localparam logic [STEP_W-1:0] ANGLE_STEP_RST     = 4'd2;

  typedef enum logic [1:0] {
    REG_NEAR_THRESHOLD = 2'd0,
    REG_SKIP_COUNT     = 2'd1,
    REG_MIN_SPAN       = 2'd2,
    REG_ANGLE_STEP     = 2'd3
  } reg_index_t;

  typedef enum logic {
    KIND_OBJECT  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // what the segmenter hands to the result stage, registered in the cycle after a request
  typedef struct packed {
    logic               valid;
    logic               obj;
    logic               sum;
    logic [SLOT_W-1:0]  obj_slot;
    logic [ANGLE_W-1:0] obj_mid_ang;
    logic [ANGLE_W-1:0] obj_span;
    logic [SLOT_W-1:0]  sum_slot;
    logic [ANGLE_W-1:0] sum_angle;
    logic [ANGLE_W-1:0] sum_span;
  } seg_req_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  mid_dist;
    logic [ANGLE_W-1:0] span;
    logic [WIDTH_W-1:0] width;
    logic               last;
  } result_t;

endpackage

// ===== src/range_sweep_object_segmenter.sv =====
// range sweep object segmenter: takes one range sample per sweep position,
// stores it in a sample memory (one write and one read port, registered
// read) and tracks runs of near samples. a closing run reads back its
// midpoint sample and yields an object record if a slot is free; the sample
// marked sweep_end also yields a summary naming the smallest-span object,
// then clears the slots and run state. a request is taken every cycle as
// long as the result queue has room: each request may cause up to two
// records, which pass a registered request stage and an eight-entry queue,
// so sustained rate is one sample per cycle while the output side keeps
// up and records stay at no more than one per sample on average.
// registers on the cfg port take effect with the next sample and should be
// written while the block is idle.
module range_sweep_object_segmenter #(
  parameter int MAX_POSITIONS = 128,
  parameter int MAX_OBJECTS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  rss_pkg::reg_index_t           cfg_index,
  input  logic [rss_pkg::CFG_W-1:0]     cfg_data,
  // sample requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rss_pkg::DIST_W-1:0]    distance,
  input  logic                          sweep_end,
  // result requests
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          record_kind,
  output logic [rss_pkg::SLOT_W-1:0]    slot,
  output logic [rss_pkg::ANGLE_W-1:0]   mid_angle,
  output logic [rss_pkg::DIST_W-1:0]    mid_distance,
  output logic [rss_pkg::ANGLE_W-1:0]   span,
  output logic [rss_pkg::WIDTH_W-1:0]   width,
  output logic                          last_of_run
);
  import rss_pkg::*;

  localparam int POS_W = $clog2(MAX_POSITIONS);

  logic                 accept;
  logic                 mem_we, mem_re;
  logic [POS_W-1:0]     mem_waddr, mem_raddr;
  logic [DIST_W-1:0]    mem_wdata, mem_rdata;
  seg_req_t             s1;
  result_t              obj_rec, sum_rec, wr0, head;
  logic [1:0]           push_n;
  logic [FIFO_CNT_W-1:0] count;
  logic                 pop;

  assign accept = in_valid && in_ready;

  // sweep state machine and run detection
  rss_seg_ctrl #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .MAX_OBJECTS  (MAX_OBJECTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .distance (distance),
    .sweep_end(sweep_end),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .s1       (s1)
  );

  // sample store, one entry per sweep position
  rss_sample_mem #(
    .DEPTH(MAX_POSITIONS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // second stage: midpoint sample is back, form the records
  always_comb begin
    obj_rec.kind     = KIND_OBJECT;
    obj_rec.slot     = s1.obj_slot;
    obj_rec.angle    = s1.obj_mid_ang;
    obj_rec.mid_dist = mem_rdata;
    obj_rec.span     = s1.obj_span;
    // width is midpoint distance times span, 12 x 11 bits
    obj_rec.width = {{(WIDTH_W - DIST_W){1'b0}}, mem_rdata} *
                    {{(WIDTH_W - ANGLE_W){1'b0}}, s1.obj_span};
    obj_rec.last  = !s1.sum;

    sum_rec.kind     = KIND_SUMMARY;
    sum_rec.slot     = s1.sum_slot;
    sum_rec.angle    = s1.sum_angle;
    sum_rec.mid_dist = '0;
    sum_rec.span     = s1.sum_span;
    sum_rec.width    = '0;
    sum_rec.last     = 1'b1;

    wr0    = s1.obj ? obj_rec : sum_rec;
    push_n = s1.valid ? (2'(s1.obj) + 2'(s1.sum)) : 2'd0;
  end

  rss_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push_n(push_n),
    .wr0   (wr0),
    .wr1   (sum_rec),
    .pop   (pop),
    .head  (head),
    .count (count)
  );

  // room for what the second stage holds plus two records of a new request
  assign in_ready = ((FIFO_CNT_W + 1)'(count) + (FIFO_CNT_W + 1)'(push_n)) <=
                    (FIFO_CNT_W + 1)'(FIFO_DEPTH - 2);

  assign out_valid    = (count != '0);
  assign pop          = out_valid && out_ready;
  assign record_kind  = head.kind;
  assign slot         = head.slot;
  assign mid_angle    = head.angle;
  assign mid_distance = head.mid_dist;
  assign span         = head.span;
  assign width        = head.width;
  assign last_of_run  = head.last;

endmodule

// ===== src/rss_sample_mem.sv =====
module rss_sample_mem #(
  parameter int DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [rss_pkg::DIST_W-1:0]       wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [rss_pkg::DIST_W-1:0]       rdata
);
  import rss_pkg::*;

  logic [DIST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rss_seg_ctrl.sv =====
module rss_seg_ctrl #(
  parameter int MAX_POSITIONS = 128,
  parameter int MAX_OBJECTS   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  rss_pkg::reg_index_t                  cfg_index,
  input  logic [rss_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 accept,
  input  logic [rss_pkg::DIST_W-1:0]           distance,
  input  logic                                 sweep_end,
  output logic                                 mem_we,
  output logic [$clog2(MAX_POSITIONS)-1:0]     mem_waddr,
  output logic [rss_pkg::DIST_W-1:0]           mem_wdata,
  output logic                                 mem_re,
  output logic [$clog2(MAX_POSITIONS)-1:0]     mem_raddr,
  output rss_pkg::seg_req_t                    s1
);
  import rss_pkg::*;

  localparam int POS_W  = $clog2(MAX_POSITIONS);
  localparam int CMP_W  = POS_W + 8;
  localparam int OBJ_W  = $clog2(MAX_OBJECTS + 1);
  localparam int BEST_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int EXT_W  = OBJ_W + SLOT_W;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_POSITIONS - 1);

  // configuration
  logic [DIST_W-1:0] near_threshold;
  logic [SKIP_W-1:0] skip_count;
  logic [SKIP_W-1:0] min_span;
  logic [STEP_W-1:0] angle_step;

  // run state
  logic [POS_W-1:0]   position, position_next;
  logic               in_run, in_run_next;
  logic [POS_W-1:0]   run_start, run_start_next;
  logic [OBJ_W-1:0]   objects_found, objects_found_next;
  logic [BEST_W-1:0]  best_slot, best_slot_next;
  logic [ANGLE_W-1:0] best_span, best_span_next;
  logic [ANGLE_W-1:0] best_angle, best_angle_next;
  seg_req_t           s1_next;

  logic               start_ok, end_ok, emit_obj, better;
  logic [POS_W-1:0]   len, mid;
  logic [ANGLE_W-1:0] ang, sp;
  logic [CMP_W-1:0]   p_ext, end_limit;
  logic [POS_W:0]     p_inc;
  logic [EXT_W-1:0]   obj_num, best_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= NEAR_THRESHOLD_RST;
      skip_count     <= SKIP_COUNT_RST;
      min_span       <= MIN_SPAN_RST;
      angle_step     <= ANGLE_STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NEAR_THRESHOLD: near_threshold <= cfg_data;
        REG_SKIP_COUNT:     skip_count     <= cfg_data[SKIP_W-1:0];
        REG_MIN_SPAN:       min_span       <= cfg_data[SKIP_W-1:0];
        REG_ANGLE_STEP:     angle_step     <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    p_ext     = CMP_W'(position);
    end_limit = CMP_W'(run_start) + CMP_W'(min_span);
    start_ok  = (p_ext >= CMP_W'(skip_count)) && (distance < near_threshold);
    end_ok    = in_run && (distance > near_threshold) && (p_ext > end_limit);
    emit_obj  = accept && end_ok && (objects_found < OBJ_W'(MAX_OBJECTS));

    // run covers run_start .. position-1
    len = position - POS_W'(1) - run_start;
    mid = run_start + (len >> 1);
    ang = ANGLE_W'(angle_step) * ANGLE_W'(mid);
    sp  = ANGLE_W'(angle_step) * ANGLE_W'(len);
    better = (objects_found == '0) || (sp < best_span);

    p_inc   = (POS_W + 1)'(position) + (POS_W + 1)'(1);
    obj_num = EXT_W'(objects_found) + EXT_W'(1);

    position_next      = position;
    in_run_next        = in_run;
    run_start_next     = run_start;
    objects_found_next = objects_found;
    best_slot_next     = best_slot;
    best_span_next     = best_span;
    best_angle_next    = best_angle;

    if (accept) begin
      if (!in_run) begin
        if (start_ok) begin
          in_run_next    = 1'b1;
          run_start_next = position;
        end
      end else if (end_ok) begin
        in_run_next = 1'b0;
      end
      if (emit_obj) begin
        objects_found_next = objects_found + OBJ_W'(1);
        if (better) begin
          best_slot_next  = objects_found[BEST_W-1:0];
          best_span_next  = sp;
          best_angle_next = ang;
        end
      end
      if (p_inc < (POS_W + 1)'(MAX_POSITIONS)) begin
        position_next = p_inc[POS_W-1:0];
      end else begin
        position_next = LAST_POS;
      end
    end

    best_ext = EXT_W'(best_slot_next);

    s1_next.valid       = accept;
    s1_next.obj         = emit_obj;
    s1_next.sum         = accept && sweep_end;
    s1_next.obj_slot    = obj_num[SLOT_W-1:0];
    s1_next.obj_mid_ang = ang;
    s1_next.obj_span    = sp;
    s1_next.sum_slot    = best_ext[SLOT_W-1:0];
    s1_next.sum_angle   = best_angle_next;
    s1_next.sum_span    = best_span_next;

    // end of sweep: clear slots and run state after the summary is taken
    if (accept && sweep_end) begin
      position_next      = '0;
      in_run_next        = 1'b0;
      run_start_next     = '0;
      objects_found_next = '0;
      best_slot_next     = '0;
      best_span_next     = '0;
      best_angle_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      in_run        <= 1'b0;
      run_start     <= '0;
      objects_found <= '0;
      best_slot     <= '0;
      best_span     <= '0;
      best_angle    <= '0;
      s1            <= '0;
    end else begin
      position      <= position_next;
      in_run        <= in_run_next;
      run_start     <= run_start_next;
      objects_found <= objects_found_next;
      best_slot     <= best_slot_next;
      best_span     <= best_span_next;
      best_angle    <= best_angle_next;
      s1            <= s1_next;
    end
  end

  // midpoint always lies below the position being written, so no bypass
  assign mem_we    = accept;
  assign mem_waddr = position;
  assign mem_wdata = distance;
  assign mem_re    = emit_obj;
  assign mem_raddr = mid;

endmodule

// ===== src/rss_result_fifo.sv =====
module rss_result_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        push_n,
  input  rss_pkg::result_t                  wr0,
  input  rss_pkg::result_t                  wr1,
  input  logic                              pop,
  output rss_pkg::result_t                  head,
  output logic [rss_pkg::FIFO_CNT_W-1:0]    count
);
  import rss_pkg::*;

  result_t               entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= wr0;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + FIFO_PTR_W'(1)] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end
  end

  assign head = entries[rd_ptr];

endmodule

// ===== src/rss_checker.sv =====
module rss_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          record_kind,
  input logic [rss_pkg::DIST_W-1:0]    mid_distance,
  input logic [rss_pkg::ANGLE_W-1:0]   span,
  input logic [rss_pkg::WIDTH_W-1:0]   width,
  input logic                          last_of_run
);
  import rss_pkg::*;

  // pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

  // summary closes the results of its request and carries no distance
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == KIND_SUMMARY |->
      last_of_run && mid_distance == '0 && width == '0)
    else $error("malformed summary record");

  // object width is midpoint distance times span
  a_obj_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == KIND_OBJECT |->
      width == ({{(WIDTH_W - DIST_W){1'b0}}, mid_distance} *
                {{(WIDTH_W - ANGLE_W){1'b0}}, span}))
    else $error("object width mismatch");

endmodule

bind range_sweep_object_segmenter rss_checker u_rss_checker (.*);

// ===== tb/range_sweep_checker.sv =====
module range_sweep_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  rss_pkg::reg_index_t         cfg_index,
  input  logic [rss_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [rss_pkg::DIST_W-1:0]  distance,
  input  logic                        sweep_end,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        record_kind,
  input  logic [rss_pkg::SLOT_W-1:0]  slot,
  input  logic [rss_pkg::ANGLE_W-1:0] mid_angle,
  input  logic [rss_pkg::DIST_W-1:0]  mid_distance,
  input  logic [rss_pkg::ANGLE_W-1:0] span,
  input  logic [rss_pkg::WIDTH_W-1:0] width,
  input  logic                        last_of_run,
  output int unsigned                 mismatches,
  output int unsigned                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rss_pkg::*;

  localparam int POSITIONS    = 128;
  localparam int OBJECT_SLOTS = 8;

  // register copies
  logic [DIST_W-1:0]  near_threshold;
  logic [SKIP_W-1:0]  skip_count;
  logic [SKIP_W-1:0]  min_span;
  logic [STEP_W-1:0]  angle_step;

  // segmenter state
  logic [DIST_W-1:0]  range_mem [POSITIONS];
  int                 position;
  bit                 in_run;
  int                 run_start;
  int                 found;
  logic [2:0]         best_slot;
  logic [ANGLE_W-1:0] best_span;
  logic [ANGLE_W-1:0] best_angle;

  result_t            records_due [$];
  int unsigned        errors;

  task automatic segment_sample(input logic [DIST_W-1:0] d, input logic last);
    int      p;
    int      len;
    int      mid;
    result_t rec;
    p = position;
    range_mem[p] = d;
    if (!in_run) begin
      if (p >= skip_count && d < near_threshold) begin
        in_run    = 1'b1;
        run_start = p;
      end
    end else if (d > near_threshold && p > run_start + min_span) begin
      in_run = 1'b0;
      // slots full: run closes silently
      if (found < OBJECT_SLOTS) begin
        len          = p - 1 - run_start;
        mid          = run_start + len / 2;
        rec.kind     = KIND_OBJECT;
        rec.slot     = SLOT_W'(found + 1);
        rec.angle    = ANGLE_W'(angle_step * mid);
        rec.mid_dist = range_mem[mid];
        rec.span     = ANGLE_W'(angle_step * len);
        rec.width    = WIDTH_W'(rec.mid_dist) * WIDTH_W'(rec.span);
        rec.last     = !last;
        records_due.push_back(rec);
        if (found == 0 || rec.span < best_span) begin
          best_slot  = 3'(found);
          best_span  = rec.span;
          best_angle = rec.angle;
        end
        found++;
      end
    end
    if (last) begin
      rec.kind     = KIND_SUMMARY;
      rec.slot     = SLOT_W'(best_slot);
      rec.angle    = best_angle;
      rec.mid_dist = '0;
      rec.span     = best_span;
      rec.width    = '0;
      rec.last     = 1'b1;
      records_due.push_back(rec);
      found      = 0;
      best_slot  = '0;
      best_span  = '0;
      best_angle = '0;
      in_run     = 1'b0;
      run_start  = 0;
      position   = 0;
    end else begin
      position = (p < POSITIONS - 1) ? p + 1 : POSITIONS - 1;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      near_threshold = NEAR_THRESHOLD_RST;
      skip_count     = SKIP_COUNT_RST;
      min_span       = MIN_SPAN_RST;
      angle_step     = ANGLE_STEP_RST;
      position       = 0;
      in_run         = 1'b0;
      run_start      = 0;
      found          = 0;
      best_slot      = '0;
      best_span      = '0;
      best_angle     = '0;
      errors         = 0;
      records_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_NEAR_THRESHOLD: near_threshold = cfg_data[DIST_W-1:0];
          REG_SKIP_COUNT:     skip_count     = cfg_data[SKIP_W-1:0];
          REG_MIN_SPAN:       min_span       = cfg_data[SKIP_W-1:0];
          REG_ANGLE_STEP:     angle_step     = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready === 1'b1) begin
        segment_sample(distance, sweep_end);
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (records_due.size() == 0) begin
          $display("%0t: result mismatch, expected none, actual kind %0d slot %0d",
                   $time, record_kind, slot);
          errors++;
        end else begin
          want = records_due.pop_front();
          check_field("record_kind", want.kind, record_kind);
          check_field("slot", want.slot, slot);
          check_field("mid_angle", want.angle, mid_angle);
          check_field("mid_distance", want.mid_dist, mid_distance);
          check_field("span", want.span, span);
          check_field("width", want.width, width);
          check_field("last_of_run", want.last, last_of_run);
        end
      end
    end
    mismatches <= errors;
    pending    <= records_due.size();
  end

endmodule

// ===== tb/tb_range_sweep_object_segmenter.sv =====
module tb_range_sweep_object_segmenter;
  timeunit 1ns;
  timeprecision 1ps;
  import rss_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 200;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_wr_en   = 1'b0;
  reg_index_t         cfg_index   = REG_NEAR_THRESHOLD;
  logic [CFG_W-1:0]   cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [DIST_W-1:0]  distance    = '0;
  logic               sweep_end   = 1'b0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic               record_kind;
  logic [SLOT_W-1:0]  slot;
  logic [ANGLE_W-1:0] mid_angle;
  logic [DIST_W-1:0]  mid_distance;
  logic [ANGLE_W-1:0] span;
  logic [WIDTH_W-1:0] width;
  logic               last_of_run;

  int unsigned        mismatches;
  int unsigned        pending;
  int                 cycle_count = 0;
  int                 sent        = 0;   // accepted sample requests, seen by the receiver
  int                 swept       = 0;   // random samples sent so far
  int                 burst_left  = 0;   // sender runs without gaps while nonzero

  // register values currently programmed, used to shape the samples
  logic [DIST_W-1:0]  thr_now;
  logic [SKIP_W-1:0]  ms_now;

  range_sweep_object_segmenter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .distance     (distance),
    .sweep_end    (sweep_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .record_kind  (record_kind),
    .slot         (slot),
    .mid_angle    (mid_angle),
    .mid_distance (mid_distance),
    .span         (span),
    .width        (width),
    .last_of_run  (last_of_run)
  );

  range_sweep_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .distance     (distance),
    .sweep_end    (sweep_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .record_kind  (record_kind),
    .slot         (slot),
    .mid_angle    (mid_angle),
    .mid_distance (mid_distance),
    .span         (span),
    .width        (width),
    .last_of_run  (last_of_run),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs or records go missing
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_range_sweep_object_segmenter: done, errors");
      $finish;
    end
  end

  // all four registers, back to back, only while the block is idle
  task automatic write_settings(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] skip,
                                input logic [CFG_W-1:0] ms, input logic [CFG_W-1:0] step);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_NEAR_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= REG_SKIP_COUNT;
    cfg_data  <= skip;
    @(posedge clk);
    cfg_index <= REG_MIN_SPAN;
    cfg_data  <= ms;
    @(posedge clk);
    cfg_index <= REG_ANGLE_STEP;
    cfg_data  <= step;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thr_now = thr[DIST_W-1:0];
    ms_now  = ms[SKIP_W-1:0];
  endtask

  // one sample request; returns at the edge where it was accepted
  task automatic send_sample(input logic [DIST_W-1:0] d, input logic last);
    int gap;
    int r;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) burst_left = 30;
      else if (r < 60) gap = 0;
      else if (r < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 20);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    distance  <= d;
    sweep_end <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    sent <= sent + 1;
  endtask

  // sweep made of alternating near and far stretches, or plain noise
  task automatic run_sweep(input int len);
    int               seg_left;
    bit               near;
    bit               noisy;
    int               r;
    logic [DIST_W-1:0] d;
    seg_left = 0;
    near     = $urandom_range(0, 1);
    noisy    = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      if (seg_left == 0) begin
        near     = !near;
        seg_left = near ? $urandom_range(1, ms_now + 3) : $urandom_range(1, 3);
      end
      seg_left--;
      r = $urandom_range(0, 99);
      if (noisy) d = $urandom_range(0, 4095);
      else if (r < 5) d = thr_now;
      else if (near) d = (thr_now > 0) ? $urandom_range(0, thr_now - 1) : '0;
      else d = (thr_now < 4095) ? $urandom_range(thr_now + 1, 4095) : 12'd4095;
      send_sample(d, i == len - 1);
      swept++;
    end
  endtask

  // drop valid, wait for every record, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // receiver: mostly ready, short and long stalls, calm stretches and
  // two long hold-offs while samples keep coming so the queue backs up
  initial begin : receiver
    int r;
    int hold_count;
    int stay;
    hold_count = 0;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (hold_count < 2 && in_valid && sent >= hold_count * 250) begin
        out_ready <= 1'b0;
        stay = HOLD_CYCLES;
        hold_count++;
      end else if (r < 5) begin
        out_ready <= 1'b1;
        stay = 40;
      end else if (r < 70) begin
        out_ready <= 1'b1;
        stay = 1;
      end else if (r < 95) begin
        out_ready <= 1'b0;
        stay = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        stay = $urandom_range(10, 30);
      end
      repeat (stay - 1) @(posedge clk);
    end
  end

  initial begin : stimulus
    // opening sweep: nine objects (last one dropped), a tie on the smallest
    // span, extremes of distance; then threshold-equal samples and a run
    // left open at sweep end with no object found
    logic [DIST_W-1:0] opening_d [24] = '{
      12'd37, 12'd0, 12'd4095, 12'd99, 12'd101, 12'd1, 12'd4094, 12'd64,
      12'd200, 12'd32, 12'd400, 12'd16, 12'd800, 12'd8, 12'd1600, 12'd4,
      12'd3200, 12'd2, 12'd4095, 12'd100, 12'd100, 12'd0, 12'd100, 12'd50};
    logic [23:0]       opening_end = 24'h880000;
    int                phase;
    int                sweeps;
    int                len;
    logic [CFG_W-1:0]  thr;
    logic [CFG_W-1:0]  skip;
    logic [CFG_W-1:0]  ms;
    logic [CFG_W-1:0]  step;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_settings(12'd100, 12'd0, 12'd0, 12'd15);
    for (int i = 0; i < 24; i++) begin
      send_sample(opening_d[i], opening_end[i]);
    end
    wait_idle();

    phase = 0;
    while (swept < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          // all registers at their maximum
          thr = 12'd4095; skip = 12'd127; ms = 12'd127; step = 12'd15;
        end
        1: begin
          // all registers at their minimum, but the angle step is one
          thr = 12'd0; skip = 12'd0; ms = 12'd0; step = 12'd1;
        end
        default: begin
          thr  = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 12'd4095 : 12'd0)
                                             : $urandom_range(20, 4000);
          skip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
          ms   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
          step = $urandom_range(1, 15);
        end
      endcase
      // zero step: every angle and span collapses to zero
      if (phase == 2) step = '0;
      write_settings(thr, skip, ms, step);
      sweeps = $urandom_range(1, 3);
      for (int s = 0; s < sweeps; s++) begin
        // one sweep runs past the store so the position saturates
        if (phase == 3 && s == 0) len = 140;
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(41, 100);
        else len = $urandom_range(1, 30);
        run_sweep(len);
      end
      wait_idle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("tb_range_sweep_object_segmenter: done, clean");
    end else begin
      $display("tb_range_sweep_object_segmenter: done, errors");
    end
    $finish;
  end

endmodule
